@@ sv/heightfield_bilinear_sample_defines.svh @@
// Assertion macros for the height-field sampler.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLE_DEFINES_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLE_DEFINES_SVH

`ifndef SYNTHESIS
`define HBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define HBS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/hbs_pkg.sv @@
// Shared constants and types of the height-field sampler.
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

    localparam int DEF_MAX_CELLS   = 65536;
    localparam int DEF_HEIGHT_BITS = 16;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPW     = $clog2(Q_DEPTH);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_DEPTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_TO_GRID  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_TO_GRID  = 2'd3;

    localparam logic [8:0]  RST_GRID_SIZE = 9'd256;
    localparam logic [23:0] RST_TO_GRID   = 24'd65536;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [8:0]  w_use;
        logic [7:0]  w_last;
        logic [7:0]  d_last;
        logic [23:0] x_to_grid;
        logic [23:0] z_to_grid;
    } t_cfg;

    typedef struct packed {
        logic               is_query;
        logic [15:0]        cell_index;
        logic signed [15:0] height_value;
        logic [7:0]         x0;
        logic [7:0]         x1;
        logic [15:0]        tx;
        logic [7:0]         z0;
        logic [7:0]         z1;
        logic [15:0]        tz;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

@@ sv/hbs_in_if.sv @@
// Request channel of the height-field sampler.
`timescale 1ns / 1ps
`default_nettype none

interface hbs_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [15:0]        cell_index;
    logic signed [15:0] height_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_z;

    modport source (
        output valid, opcode, cell_index, height_value, query_x, query_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, cell_index, height_value, query_x, query_z,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/hbs_out_if.sv @@
// Result channel of the height-field sampler.
`timescale 1ns / 1ps
`default_nettype none

interface hbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height;
    logic               grid_empty;

    modport source (
        output valid, height, grid_empty,
        input  ready
    );
    modport sink (
        input  valid, height, grid_empty,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/hbs_front.sv @@
// Front end: takes requests, scales query coordinates and picks the clamped cells.
`timescale 1ns / 1ps
`default_nettype none

module hbs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hbs_pkg::t_cfg i_cfg,
    hbs_in_if.sink        i_req,
    output hbs_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import hbs_pkg::*;

    typedef struct packed {
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [15:0] frac;
    } t_axis;

    // cell = floor(prod / 2^32), fraction = bits 31:16; clamp to edge
    function automatic t_axis locate(input logic [56:0] prod, input logic [7:0] last);
        t_axis       a;
        logic [24:0] grid_cell;
        grid_cell = prod[56:32];
        a         = '0;
        if (grid_cell[24]) begin
            a = '0;
        end else if (grid_cell[23:0] >= {16'b0, last}) begin
            a.c0 = last;
            a.c1 = last;
        end else begin
            a.c0   = grid_cell[7:0];
            a.c1   = grid_cell[7:0] + 8'd1;
            a.frac = prod[31:16];
        end
        return a;
    endfunction

    logic               r_s1_valid;
    logic               r_s1_op;
    logic [15:0]        r_s1_idx;
    logic signed [15:0] r_s1_hv;
    logic signed [31:0] r_s1_qx;
    logic signed [31:0] r_s1_qz;

    logic               r_s2_valid;
    logic               r_s2_op;
    logic [15:0]        r_s2_idx;
    logic signed [15:0] r_s2_hv;
    logic signed [56:0] r_s2_px;
    logic signed [56:0] r_s2_pz;

    logic signed [56:0] n_s2_px;
    logic signed [56:0] n_s2_pz;
    logic               s1_adv;
    logic               s2_adv;
    t_axis              ax;
    t_axis              az;

    assign s2_adv      = !r_s2_valid || i_cmd_ready;
    assign s1_adv      = !r_s1_valid || s2_adv;
    assign i_req.ready = s1_adv;

    always_comb begin
        n_s2_px = r_s1_qx * $signed({1'b0, i_cfg.x_to_grid});
        n_s2_pz = r_s1_qz * $signed({1'b0, i_cfg.z_to_grid});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_req.valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_op  <= i_req.opcode;
            r_s1_idx <= i_req.cell_index;
            r_s1_hv  <= i_req.height_value;
            r_s1_qx  <= i_req.query_x;
            r_s1_qz  <= i_req.query_z;
        end
        if (s2_adv) begin
            r_s2_op  <= r_s1_op;
            r_s2_idx <= r_s1_idx;
            r_s2_hv  <= r_s1_hv;
            r_s2_px  <= n_s2_px;
            r_s2_pz  <= n_s2_pz;
        end
    end

    always_comb begin
        ax                 = locate(r_s2_px, i_cfg.w_last);
        az                 = locate(r_s2_pz, i_cfg.d_last);
        o_cmd.is_query     = (r_s2_op == OP_QUERY);
        o_cmd.cell_index   = r_s2_idx;
        o_cmd.height_value = r_s2_hv;
        o_cmd.x0           = ax.c0;
        o_cmd.x1           = ax.c1;
        o_cmd.tx           = ax.frac;
        o_cmd.z0           = az.c0;
        o_cmd.z1           = az.c1;
        o_cmd.tz           = az.frac;
    end

    assign o_cmd_valid = r_s2_valid;

endmodule

`default_nettype wire

@@ sv/hbs_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module hbs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hbs_pkg::t_cmd   i_push_data,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output hbs_pkg::t_cmd   o_pop_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output hbs_pkg::t_qstat o_stat
);
    import hbs_pkg::*;

    t_cmd           r_buf [Q_DEPTH];
    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QPW:0]   r_count;

    logic push;
    logic pop;

    assign o_stat.full  = (r_count == (QPW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_push_ready = !o_stat.full;
    assign o_pop_valid  = !o_stat.empty;
    assign o_pop_data   = r_buf[r_rptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/hbs_back.sv @@
// Back end: height store, four corner reads and the bilinear blend.
`timescale 1ns / 1ps
`default_nettype none

module hbs_back #(
    parameter int MAX_CELLS   = hbs_pkg::DEF_MAX_CELLS,
    parameter int HEIGHT_BITS = hbs_pkg::DEF_HEIGHT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hbs_pkg::t_cfg i_cfg,
    input  hbs_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    hbs_out_if.source     o_res
);
    import hbs_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int IW = (AW > 16) ? AW : 16;
    localparam logic [IW:0] CELLS = (IW + 1)'(MAX_CELLS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_RD3  = 3'd4;
    localparam logic [2:0] ST_MIX0 = 3'd5;
    localparam logic [2:0] ST_MIX1 = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [HEIGHT_BITS-1:0] r_mem [MAX_CELLS];
    logic [HEIGHT_BITS-1:0] r_rdata;
    logic                   r_rd_ok;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic               r_any_written;
    logic [15:0]        r_rb0;
    logic [15:0]        r_rb1;
    logic [7:0]         r_x0;
    logic [7:0]         r_x1;
    logic [15:0]        r_tx;
    logic [15:0]        r_tz;
    logic signed [15:0] r_h00;
    logic signed [15:0] r_h10;
    logic signed [15:0] r_h01;
    logic signed [31:0] r_h0;
    logic signed [31:0] r_h1;
    logic signed [15:0] r_res;
    logic               r_res_empty;

    logic               r_out_valid;
    logic signed [15:0] r_out_height;
    logic               r_out_empty;

    logic [15:0]            mem_idx;
    logic [IW-1:0]          mem_wide;
    logic                   mem_ok;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic [HEIGHT_BITS-1:0] mem_wdata;
    logic signed [15:0]     rd_h;
    logic                   out_load;

    logic signed [15:0] row_a;
    logic signed [15:0] row_b;
    logic signed [16:0] row_d;
    logic signed [33:0] row_p;
    logic [33:0]        row_s;
    logic signed [32:0] fin_d;
    logic signed [49:0] fin_p;
    logic [49:0]        fin_s;

    // corner select; the idle state addresses the write of a popped command
    always_comb begin
        case (r_state)
            ST_RD0:  mem_idx = r_rb0 + {8'b0, r_x0};
            ST_RD1:  mem_idx = r_rb0 + {8'b0, r_x1};
            ST_RD2:  mem_idx = r_rb1 + {8'b0, r_x0};
            ST_RD3:  mem_idx = r_rb1 + {8'b0, r_x1};
            default: mem_idx = i_cmd.cell_index;
        endcase
        mem_wide  = IW'(mem_idx);
        mem_ok    = ({1'b0, mem_wide} < CELLS);
        mem_addr  = mem_wide[AW-1:0];
        mem_wdata = HEIGHT_BITS'(i_cmd.height_value);
        rd_h      = r_rd_ok ? 16'($signed(r_rdata)) : 16'sd0;
    end

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_pop = 1'b1;
                if (i_cmd_valid) begin
                    if (!i_cmd.is_query) begin
                        mem_we = mem_ok;
                    end else if (!r_any_written) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_RD3;
            ST_RD3:  n_state = ST_MIX0;
            ST_MIX0: n_state = ST_MIX1;
            ST_MIX1: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // one row blend unit, shared by both rows: a*(1-t) + b*t in Q.16
    always_comb begin
        row_a = (r_state == ST_MIX0) ? r_h01 : r_h00;
        row_b = (r_state == ST_MIX0) ? rd_h : r_h10;
        row_d = {row_b[15], row_b} - {row_a[15], row_a};
        row_p = row_d * $signed({1'b0, r_tx});
        row_s = {{2{row_a[15]}}, row_a, 16'b0} + row_p;
        fin_d = {r_h1[31], r_h1} - {r_h0[31], r_h0};
        fin_p = fin_d * $signed({1'b0, r_tz});
        fin_s = {{2{r_h0[31]}}, r_h0, 16'b0} + fin_p;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
        r_rd_ok <= mem_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_any_written <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_any_written <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_rb0       <= {8'b0, i_cmd.z0} * {7'b0, i_cfg.w_use};
                r_rb1       <= {8'b0, i_cmd.z1} * {7'b0, i_cfg.w_use};
                r_x0        <= i_cmd.x0;
                r_x1        <= i_cmd.x1;
                r_tx        <= i_cmd.tx;
                r_tz        <= i_cmd.tz;
                r_res       <= 16'sd0;
                r_res_empty <= 1'b1;
            end
            ST_RD1: r_h00 <= rd_h;
            ST_RD2: r_h10 <= rd_h;
            ST_RD3: begin
                r_h01 <= rd_h;
                r_h0  <= row_s[31:0];
            end
            ST_MIX0: r_h1 <= row_s[31:0];
            ST_MIX1: begin
                r_res       <= fin_s[47:32];
                r_res_empty <= 1'b0;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_height <= r_res;
            r_out_empty  <= r_res_empty;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.height     = r_out_height;
    assign o_res.grid_empty = r_out_empty;

endmodule

`default_nettype wire

@@ sv/heightfield_bilinear_sample.sv @@
// Top level of the bilinear height-field sampler.
`timescale 1ns / 1ps
`default_nettype none

`include "heightfield_bilinear_sample_defines.svh"

// Height-field sampler: a write request (opcode 0) stores a Q8.8 height at a cell
// index; a query request (opcode 1) scales its Q16.16 x and z by the Q8.16 factors,
// clamps the cells to the grid in use and returns the truncated bilinear blend of
// four corner heights, or height 0 with grid_empty set while nothing has been
// written. A two-stage front end scales and clamps coordinates and feeds a
// four-entry command queue; the back end owns the single-port height store. A write
// is done in the idle state; a query forms row addresses, makes four store reads
// on the single port, blends the two rows and then the result and loads the
// output register. An empty-grid query goes straight to the output register. The
// store is not cleared after reset; reading a cell never written gives an undefined
// height. Write configuration only while no request is in flight.
module heightfield_bilinear_sample #(
    parameter int MAX_CELLS   = hbs_pkg::DEF_MAX_CELLS,
    parameter int HEIGHT_BITS = hbs_pkg::DEF_HEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [hbs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    hbs_in_if.sink                             i_req,
    hbs_out_if.source                          o_res
);
    import hbs_pkg::*;

    logic [8:0]  r_grid_width;
    logic [8:0]  r_grid_depth;
    logic [23:0] r_x_to_grid;
    logic [23:0] r_z_to_grid;

    t_cfg   cfg;
    logic [8:0] d_use;
    t_cmd   f_cmd;
    logic   f_valid;
    logic   q_ready;
    t_cmd   q_cmd;
    logic   q_valid;
    logic   b_pop;
    t_qstat q_stat;
    logic   q_push;
    logic   q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= RST_GRID_SIZE;
            r_grid_depth <= RST_GRID_SIZE;
            r_x_to_grid  <= RST_TO_GRID;
            r_z_to_grid  <= RST_TO_GRID;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data[8:0];
                CFG_GRID_DEPTH: r_grid_depth <= i_cfg_data[8:0];
                CFG_X_TO_GRID:  r_x_to_grid  <= i_cfg_data;
                CFG_Z_TO_GRID:  r_z_to_grid  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sizes in use: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (r_grid_width == 9'd0) begin
            cfg.w_use = 9'd1;
        end else if (r_grid_width > RST_GRID_SIZE) begin
            cfg.w_use = RST_GRID_SIZE;
        end else begin
            cfg.w_use = r_grid_width;
        end
        if (r_grid_depth == 9'd0) begin
            d_use = 9'd1;
        end else if (r_grid_depth > RST_GRID_SIZE) begin
            d_use = RST_GRID_SIZE;
        end else begin
            d_use = r_grid_depth;
        end
        cfg.w_last    = 8'(cfg.w_use - 9'd1);
        cfg.d_last    = 8'(d_use - 9'd1);
        cfg.x_to_grid = r_x_to_grid;
        cfg.z_to_grid = r_z_to_grid;
    end

    hbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (q_ready)
    );

    hbs_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (f_cmd),
        .i_push_valid (f_valid),
        .o_push_ready (q_ready),
        .o_pop_data   (q_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (b_pop),
        .o_stat       (q_stat)
    );

    hbs_back #(
        .MAX_CELLS   (MAX_CELLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (b_pop),
        .o_res       (o_res)
    );

    assign q_push = f_valid && q_ready;
    assign q_pop  = q_valid && b_pop;

    `HBS_ASSERT_NOW(a_empty_gives_zero, i_clk, i_rst_n, o_res.valid && o_res.grid_empty, o_res.height == 16'sd0)
    `HBS_ASSERT_NOW(a_queue_flags, i_clk, i_rst_n, 1'b1, !(q_stat.full && q_stat.empty))
    `HBS_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire
